// File: sv/ofdm_subcarrier_allocator_assert.svh
// Assertion helpers for the subcarrier allocator.
`ifndef OFDM_SUBCARRIER_ALLOCATOR_ASSERT_SVH
`define OFDM_SUBCARRIER_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define OSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, checked while out of reset.
`define OSA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// File: sv/osa_pkg.sv
package osa_pkg;

  localparam int unsigned IDX_W  = 14;
  localparam int unsigned SLOT_W = 14;
  localparam int unsigned TOT_W  = 15;
  localparam int unsigned LG_W   = 5;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned ADDR_W = 4;

  localparam logic [LG_W-1:0] LG_MIN = LG_W'(7);

  // floor(y / 25) == (y * RECIP_25) >> RECIP_SHIFT, exact for y below 2^20
  localparam int unsigned   RECIP_SHIFT = 25;
  localparam int unsigned   RECIP_W     = 21;
  localparam logic [20:0]   RECIP_25    = 21'd1342178;

  localparam logic [ADDR_W-1:0] CFG_FFT_LOG2  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] CFG_NULL_DENS = ADDR_W'(1);

  typedef enum logic [1:0] {
    CLS_NULL   = 2'd0,
    CLS_PILOT  = 2'd1,
    CLS_DATA   = 2'd2,
    CLS_UNUSED = 2'd3
  } osa_class_e;

  // classified carrier, front to back
  typedef struct packed {
    osa_class_e        cls;
    logic [SLOT_W-1:0] slot;   // null slot, zero otherwise
    logic              last;
    logic              first;  // index 0: restart counters
    logic [TOT_W-1:0]  ztot;
  } osa_item_t;

  typedef struct packed {
    osa_class_e        cls;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic [TOT_W-1:0]  ztot;
    logic [TOT_W-1:0]  ptot;
    logic [TOT_W-1:0]  dtot;
  } osa_res_t;

  typedef struct packed {
    logic full;
    logic valid;
  } osa_qstat_t;

endpackage

// File: sv/osa_front.sv
module osa_front #(
  parameter int unsigned MAX_FFT_LOG2 = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [3:0]                      fft_log2_i,
  input  logic [osa_pkg::CFG_W-1:0]       density_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [osa_pkg::IDX_W-1:0]       index_i,
  input  logic                            full_i,
  output logic                            push_o,
  output osa_pkg::osa_item_t              item_o
);

  localparam int unsigned NW = MAX_FFT_LOG2 + 1;
  localparam int unsigned CW = ((NW > osa_pkg::IDX_W) ? NW : osa_pkg::IDX_W) + 1;
  localparam int unsigned YW = MAX_FFT_LOG2 + 4;
  localparam int unsigned PW = YW + osa_pkg::RECIP_W;

  logic                          vld_q;
  logic [osa_pkg::IDX_W-1:0]     idx_q;
  logic [osa_pkg::LG_W-1:0]      lg_q;
  logic [MAX_FFT_LOG2-1:0]       quo_q;

  logic [osa_pkg::LG_W-1:0]      lg_d;
  logic [YW-1:0]                 y;
  logic [PW-1:0]                 prod;

  // clamp FFT size and scale density by nfft/8
  always_comb begin
    lg_d = {1'b0, fft_log2_i};
    if (lg_d < osa_pkg::LG_MIN) begin
      lg_d = osa_pkg::LG_MIN;
    end else if (lg_d > osa_pkg::LG_W'(MAX_FFT_LOG2)) begin
      lg_d = osa_pkg::LG_W'(MAX_FFT_LOG2);
    end
  end

  assign y    = YW'(density_i) << (lg_d - osa_pkg::LG_W'(3));
  assign prod = PW'(y) * PW'(osa_pkg::RECIP_25);

  assign ready_o = !vld_q || push_o;
  assign push_o  = vld_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      idx_q <= index_i;
      lg_q  <= lg_d;
      quo_q <= prod[osa_pkg::RECIP_SHIFT +: MAX_FFT_LOG2];
    end
  end

  logic [CW-1:0] nfft, half, zraw, z, h, ix;
  logic          even_first, pilot;

  always_comb begin
    nfft       = CW'(1) << lg_q;
    half       = nfft >> 1;
    zraw       = (CW'(quo_q) << 1) + CW'(2);
    z          = (zraw > nfft) ? nfft : zraw;
    h          = z >> 1;
    ix         = CW'(idx_q);
    even_first = h[0];
    pilot      = 1'b0;

    item_o       = '0;
    item_o.ztot  = osa_pkg::TOT_W'(z);
    item_o.cls   = osa_pkg::CLS_UNUSED;

    if (ix < nfft) begin
      item_o.first = (ix == '0);
      item_o.last  = (ix == nfft - CW'(1));
      priority if (ix < h - CW'(1)) begin
        item_o.cls  = osa_pkg::CLS_NULL;
        item_o.slot = osa_pkg::SLOT_W'(ix);
      end else if (ix == half - CW'(1)) begin
        item_o.cls  = osa_pkg::CLS_NULL;
        item_o.slot = osa_pkg::SLOT_W'(h - CW'(1));
      end else if (ix == half) begin
        item_o.cls  = osa_pkg::CLS_NULL;
        item_o.slot = osa_pkg::SLOT_W'(h);
      end else if (ix >= nfft - h + CW'(1)) begin
        item_o.cls  = osa_pkg::CLS_NULL;
        item_o.slot = osa_pkg::SLOT_W'(ix + z - nfft);
      end else begin
        // forced pilots next to DC and the upper guard, else alternate
        priority if (ix == half - CW'(2) || ix == nfft - h) begin
          pilot = 1'b1;
        end else if (ix < half) begin
          pilot = (ix[0] != even_first);
        end else begin
          pilot = (ix[0] == even_first);
        end
        item_o.cls = pilot ? osa_pkg::CLS_PILOT : osa_pkg::CLS_DATA;
      end
    end
  end

endmodule

// File: sv/osa_queue.sv
module osa_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  osa_pkg::osa_item_t   item_i,
  input  logic                 pop_i,
  output osa_pkg::osa_item_t   item_o,
  output osa_pkg::osa_qstat_t  stat_o
);

  osa_pkg::osa_item_t mem_q [2];
  logic               wptr_q, rptr_q;
  logic [1:0]         cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.valid = (cnt_q != 2'd0);
  assign item_o       = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

// File: sv/osa_back.sv
module osa_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  osa_pkg::osa_item_t   item_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output osa_pkg::osa_res_t    res_o
);

  logic [osa_pkg::TOT_W-1:0] pcnt_q, pcnt_d, dcnt_q, dcnt_d;
  logic [osa_pkg::TOT_W-1:0] pbase, dbase;
  logic                      vld_q;
  osa_pkg::osa_res_t         res_q, res_d;

  assign pop_o   = valid_i && (!vld_q || ready_i);
  assign valid_o = vld_q;
  assign res_o   = res_q;

  // restart both counts on index 0
  assign pbase = item_i.first ? '0 : pcnt_q;
  assign dbase = item_i.first ? '0 : dcnt_q;

  always_comb begin
    pcnt_d     = pcnt_q;
    dcnt_d     = dcnt_q;
    res_d      = res_q;
    if (pop_o) begin
      pcnt_d = pbase;
      dcnt_d = dbase;
      res_d.cls  = item_i.cls;
      res_d.last = item_i.last;
      res_d.ztot = item_i.ztot;
      unique case (item_i.cls)
        osa_pkg::CLS_PILOT: begin
          res_d.slot = pbase[osa_pkg::SLOT_W-1:0];
          pcnt_d     = pbase + osa_pkg::TOT_W'(1);
        end
        osa_pkg::CLS_DATA: begin
          res_d.slot = dbase[osa_pkg::SLOT_W-1:0];
          dcnt_d     = dbase + osa_pkg::TOT_W'(1);
        end
        osa_pkg::CLS_NULL: begin
          res_d.slot = item_i.slot;
        end
        default: begin
          res_d.slot = '0;
        end
      endcase
      res_d.ptot = pcnt_d;
      res_d.dtot = dcnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pcnt_q <= '0;
      dcnt_q <= '0;
    end else begin
      pcnt_q <= pcnt_d;
      dcnt_q <= dcnt_d;
      if (pop_o) begin
        vld_q <= 1'b1;
      end else if (ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// File: sv/ofdm_subcarrier_allocator.sv
// OFDM subcarrier allocator.
// Feed subcarrier indices on the s_axis stream, ascending from 0, one per
// request; each index gives exactly one result on m_axis, in order.
// The result names the carrier class (null, pilot, data or unused), its slot
// within that class, the null count from configuration and the running pilot
// and data counts; tlast marks the last carrier of the FFT.
// Configuration writes (register 0: log2 FFT size, register 1: null density
// in percent) go over the cfg channel, which is always ready; write only
// while no request is in flight.
// Throughput: one carrier per clock while m_axis_tready stays high, set by the
// counter update in the back end. A request passes the input register with the
// null-count multiply, the two-entry queue and the output register to tvalid.
// A stalled receiver holds the output register; the queue and the input
// register then fill and tready drops the cycle after m_axis_tready falls
// when running at full rate, without losing a request.
// Reset restores log2 size 10 and density 0, clears pilot and data counts and
// empties the pipeline.
module ofdm_subcarrier_allocator #(
  parameter int unsigned MAX_FFT_LOG2 = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // carrier_index
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // carrier_class, class_slot, null_total, pilot_total, data_total
  output logic [63:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,   // is_last_carrier
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [osa_pkg::ADDR_W-1:0]    cfg_addr_i,
  input  logic [osa_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [3:0]                fft_log2_q;
  logic [osa_pkg::CFG_W-1:0] density_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fft_log2_q <= 4'd10;
      density_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_addr_i == osa_pkg::CFG_FFT_LOG2) begin
        fft_log2_q <= cfg_data_i[3:0];
      end else if (cfg_addr_i == osa_pkg::CFG_NULL_DENS) begin
        density_q <= cfg_data_i;
      end
    end
  end

  logic                push;
  logic                pop;
  osa_pkg::osa_item_t  front_item, queue_item;
  osa_pkg::osa_qstat_t qstat;
  osa_pkg::osa_res_t   res;

  osa_front #(
    .MAX_FFT_LOG2(MAX_FFT_LOG2)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fft_log2_i (fft_log2_q),
    .density_i  (density_q),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .index_i    (s_axis_tdata[osa_pkg::IDX_W-1:0]),
    .full_i     (qstat.full),
    .push_o     (push),
    .item_o     (front_item)
  );

  osa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (queue_item),
    .stat_o (qstat)
  );

  osa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qstat.valid),
    .item_i  (queue_item),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {3'b000, res.dtot, res.ptot, res.ztot, res.slot, res.cls};
  assign m_axis_tlast = res.last;

  logic pilot_out, data_out, pilot_cnt_ok, data_cnt_ok, last_out, last_ok;

  assign pilot_out    = m_axis_tvalid && (res.cls == osa_pkg::CLS_PILOT);
  assign data_out     = m_axis_tvalid && (res.cls == osa_pkg::CLS_DATA);
  assign pilot_cnt_ok = res.ptot[osa_pkg::SLOT_W-1:0] == res.slot + osa_pkg::SLOT_W'(1);
  assign data_cnt_ok  = res.dtot[osa_pkg::SLOT_W-1:0] == res.slot + osa_pkg::SLOT_W'(1);
  assign last_out     = m_axis_tvalid && m_axis_tlast;
  assign last_ok      = (res.cls != osa_pkg::CLS_UNUSED);

`include "ofdm_subcarrier_allocator_assert.svh"

  // a pilot's count after it is its slot plus one
  `OSA_ASSERT_IMP(a_pilot_count, clk_i, rst_ni, pilot_out, pilot_cnt_ok)
  // likewise for data carriers
  `OSA_ASSERT_IMP(a_data_count, clk_i, rst_ni, data_out, data_cnt_ok)
  // the last carrier is always inside the FFT
  `OSA_ASSERT_IMP(a_last_in_range, clk_i, rst_ni, last_out, last_ok)
  // a popped request always lands in the output register
  `OSA_ASSERT_NXT(a_pop_lands, clk_i, rst_ni, pop, m_axis_tvalid)

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MAX_FFT_LOG2  = 14;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned HOLD_LEN      = 300;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 1450;
  localparam int unsigned REPEAT_PAIRS  = 100;

  // register indexes the block does not decode; writes there must be ignored
  localparam logic [osa_pkg::ADDR_W-1:0] CFG_UNMAPPED_LO = osa_pkg::ADDR_W'(2);
  localparam logic [osa_pkg::ADDR_W-1:0] CFG_UNMAPPED_HI = osa_pkg::ADDR_W'(15);

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata  = '0;   // carrier_index
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // carrier_class, class_slot, null_total, pilot_total, data_total
  logic [63:0]                  m_axis_tdata;
  logic                         m_axis_tlast;         // is_last_carrier
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [osa_pkg::ADDR_W-1:0]   cfg_addr_i    = '0;
  logic [osa_pkg::CFG_W-1:0]    cfg_data_i    = '0;

  ofdm_subcarrier_allocator #(
    .MAX_FFT_LOG2(MAX_FFT_LOG2)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // allocator state as the block should hold it
  logic [3:0]                cfg_lg    = 4'd10;
  logic [osa_pkg::CFG_W-1:0] cfg_dens  = '0;
  logic [osa_pkg::TOT_W-1:0] pilot_cnt = '0;
  logic [osa_pkg::TOT_W-1:0] data_cnt  = '0;

  osa_pkg::osa_res_t pending_alloc[$];
  osa_pkg::osa_res_t alloc_head;
  int unsigned       err_count     = 0;
  int unsigned       carriers_sent = 0;
  bit                idling_on     = 1'b1;
  bit                rx_hold_req   = 1'b0;

  function automatic int unsigned fft_log2_eff(input int unsigned lg);
    if (lg < 7) return 7;
    if (lg > MAX_FFT_LOG2) return MAX_FFT_LOG2;
    return lg;
  endfunction

  function automatic osa_pkg::osa_res_t allocate_carrier(
      input logic [osa_pkg::IDX_W-1:0] idx);
    osa_pkg::osa_res_t r;
    int unsigned       nfft, z, h, half, i;
    bit                even_first, pilot;
    nfft = 1 << fft_log2_eff(cfg_lg);
    z = (nfft * cfg_dens) / 200 * 2 + 2;
    if (z > nfft) z = nfft;
    h = z / 2;
    half = nfft / 2;
    even_first = ((h - 1) % 2) == 0;
    i = idx;
    r.cls  = osa_pkg::CLS_UNUSED;
    r.slot = '0;
    r.last = 1'b0;
    r.ztot = osa_pkg::TOT_W'(z);
    if (i < nfft) begin
      if (i == 0) begin
        pilot_cnt = '0;
        data_cnt  = '0;
      end
      r.last = (i == nfft - 1);
      if (i < h - 1) begin
        r.cls = osa_pkg::CLS_NULL; r.slot = osa_pkg::SLOT_W'(i);
      end else if (i == half - 1) begin
        r.cls = osa_pkg::CLS_NULL; r.slot = osa_pkg::SLOT_W'(h - 1);
      end else if (i == half) begin
        r.cls = osa_pkg::CLS_NULL; r.slot = osa_pkg::SLOT_W'(h);
      end else if (i >= nfft - h + 1) begin
        r.cls = osa_pkg::CLS_NULL; r.slot = osa_pkg::SLOT_W'(i + z - nfft);
      end else begin
        if (i == half - 2 || i == nfft - h) pilot = 1'b1;
        else if (i < half) pilot = (i % 2) != even_first;
        else pilot = (i % 2) == even_first;
        if (pilot) begin
          r.cls = osa_pkg::CLS_PILOT; r.slot = pilot_cnt[osa_pkg::SLOT_W-1:0];
          pilot_cnt = pilot_cnt + 1'b1;
        end else begin
          r.cls = osa_pkg::CLS_DATA; r.slot = data_cnt[osa_pkg::SLOT_W-1:0];
          data_cnt = data_cnt + 1'b1;
        end
      end
    end
    r.ptot = pilot_cnt;
    r.dtot = data_cnt;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones; none with idling off
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void compare_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  task automatic send_carrier(input logic [osa_pkg::IDX_W-1:0] idx);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_alloc.push_back(allocate_carrier(idx));
    carriers_sent++;
  endtask

  // drain the pipeline, then write both registers (optionally stray indexes first)
  task automatic program_alloc(input logic [3:0] lg, input logic [osa_pkg::CFG_W-1:0] dens,
                               input bit with_stray);
    logic [osa_pkg::ADDR_W-1:0] addr[4];
    logic [osa_pkg::CFG_W-1:0]  data[4];
    int unsigned                n, k;
    n = 0;
    if (with_stray) begin
      addr[0] = CFG_UNMAPPED_LO; data[0] = '1;
      addr[1] = CFG_UNMAPPED_HI; data[1] = '1;
      n = 2;
    end
    addr[n] = osa_pkg::CFG_FFT_LOG2;  data[n] = {3'b000, lg};
    addr[n+1] = osa_pkg::CFG_NULL_DENS; data[n+1] = dens;
    n = n + 2;
    s_axis_tvalid <= 1'b0;
    while (pending_alloc.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= addr[k];
      cfg_data_i  <= data[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (addr[k])
        osa_pkg::CFG_FFT_LOG2:  cfg_lg = data[k][3:0];
        osa_pkg::CFG_NULL_DENS: cfg_dens = data[k];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // reset values: 1024 points, two nulls at DC only
  task automatic test_reset_defaults();
    send_carrier(14'd0);
    send_carrier(14'd1);
    send_carrier(14'd2);
    send_carrier(14'd510);
    send_carrier(14'd511);
    send_carrier(14'd512);
    send_carrier(14'd513);
    send_carrier(14'd514);
    send_carrier(14'd1023);
    send_carrier(14'd1024);
    send_carrier(14'h3FFF);
  endtask

  // size below range saturates to 128, density above 100 clamps to all null
  task automatic test_all_null();
    program_alloc(4'd0, 7'd127, 1'b0);
    send_carrier(14'd0);
    send_carrier(14'd64);
    send_carrier(14'd127);
    send_carrier(14'd128);
  endtask

  // size above range saturates to 16384; half the carriers are guards
  task automatic test_guard_boundaries();
    program_alloc(4'd15, 7'd50, 1'b1);
    send_carrier(14'd0);
    send_carrier(14'd4095);
    send_carrier(14'd4096);
    send_carrier(14'd8190);
    send_carrier(14'd8191);
    send_carrier(14'd8192);
    send_carrier(14'd8193);
    send_carrier(14'd12287);
    send_carrier(14'd12288);
    send_carrier(14'h3FFF);
  endtask

  task automatic test_random_passes();
    int unsigned               start, r, kind, lg, nfft, i;
    logic [osa_pkg::CFG_W-1:0] dens;
    start = carriers_sent;
    while (carriers_sent - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) lg = 7;
      else if (r < 75) lg = 8;
      else if (r < 85) lg = $urandom_range(0, 6);
      else lg = $urandom_range(9, 15);
      r = $urandom_range(0, 9);
      if (r < 2) dens = 7'd0;
      else if (r < 4) dens = 7'd100;
      else if (r < 5) dens = 7'd127;
      else dens = osa_pkg::CFG_W'($urandom_range(0, 127));
      program_alloc(4'(lg), dens, 1'b0);
      nfft = 1 << fft_log2_eff(lg);
      kind = $urandom_range(0, 9);
      if (kind < 7 && nfft <= 256) begin
        for (i = 0; i < nfft; i++) send_carrier(osa_pkg::IDX_W'(i));
      end else if (kind < 9 || nfft > 256) begin
        // ascending with skips, closing on the last carrier
        i = 0;
        while (i < nfft - 1) begin
          send_carrier(osa_pkg::IDX_W'(i));
          if ($urandom_range(0, 3) == 0) i += $urandom_range(1, nfft / 16);
          else i += 1;
        end
        send_carrier(osa_pkg::IDX_W'(nfft - 1));
      end else begin
        // out of order, repeated and out of range indices
        repeat (30) begin
          if ($urandom_range(0, 1) == 0) begin
            send_carrier(osa_pkg::IDX_W'($urandom_range(0, 2 * nfft - 1)));
          end else begin
            send_carrier(osa_pkg::IDX_W'($urandom_range(0, 16383)));
          end
        end
      end
    end
  endtask

  // receiver holds off while the sender keeps offering a full pass
  task automatic test_backpressure();
    int unsigned i;
    program_alloc(4'd7, 7'd20, 1'b0);
    idling_on = 1'b0;
    rx_hold_req = 1'b1;
    for (i = 0; i < 128; i++) send_carrier(osa_pkg::IDX_W'(i));
    idling_on = 1'b1;
  endtask

  // repeat a forced pilot and a data carrier so the counts run past one pass
  task automatic test_repeated_carriers();
    program_alloc(4'd7, 7'd0, 1'b0);
    idling_on = 1'b0;
    send_carrier(14'd0);
    repeat (REPEAT_PAIRS) begin
      send_carrier(14'd127);
      send_carrier(14'd1);
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_all_null();
    test_guard_boundaries();
    test_random_passes();
    test_backpressure();
    test_repeated_carriers();
    s_axis_tvalid <= 1'b0;
    while (pending_alloc.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[ofdm_subcarrier_allocator] OK");
    end else begin
      $display("[ofdm_subcarrier_allocator] ERROR");
    end
    $finish;
  end

  // receiver: random ready bursts and gaps, plus one long hold on request
  initial begin : rx_ready_proc
    int unsigned rx_hold_cnt;
    int unsigned g;
    bit          rx_on;
    rx_hold_cnt = 0;
    rx_on = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) continue;
      if (rx_hold_cnt > 0) begin
        rx_hold_cnt--;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_on = 1'b0;
        m_axis_tready <= 1'b0;
        rx_hold_cnt = HOLD_LEN;
      end else if (!rx_on) begin
        rx_on = 1'b1;
        m_axis_tready <= 1'b1;
        rx_hold_cnt = idling_on ? $urandom_range(0, 24) : 0;
      end else if (idling_on) begin
        g = pick_gap();
        if (g > 0) begin
          rx_on = 1'b0;
          m_axis_tready <= 1'b0;
          rx_hold_cnt = g - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_alloc.size() == 0) begin
        $error("result with no pending request, tdata %h", m_axis_tdata);
        err_count++;
      end else begin
        alloc_head = pending_alloc.pop_front();
        compare_field("carrier_class", alloc_head.cls, m_axis_tdata[1:0]);
        compare_field("class_slot", alloc_head.slot, m_axis_tdata[15:2]);
        compare_field("is_last_carrier", alloc_head.last, m_axis_tlast);
        compare_field("null_total", alloc_head.ztot, m_axis_tdata[30:16]);
        compare_field("pilot_total", alloc_head.ptot, m_axis_tdata[45:31]);
        compare_field("data_total", alloc_head.dtot, m_axis_tdata[60:46]);
      end
    end
  end

  // end the run if no request moves on any channel for too long
  initial begin : stall_watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[ofdm_subcarrier_allocator] ERROR");
    $finish;
  end

endmodule
